@@ hdl/stscan_pkg.sv @@
// Shared types and constants for the source token scanner.
// Used by the front end, the step queue, the token back end and the top level.
package stscan_pkg;

  localparam int IDENT_CHARS = 8;
  localparam int MAX_NUMBER  = 32767;
  localparam int ACC_W       = $clog2(MAX_NUMBER + 1);
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  typedef enum logic [4:0] {
    KIND_UNKNOWN   = 5'd0,
    KIND_NUMBER    = 5'd1,
    KIND_PLUS      = 5'd2,
    KIND_MINUS     = 5'd3,
    KIND_TIMES     = 5'd4,
    KIND_SLASH     = 5'd5,
    KIND_LPAREN    = 5'd6,
    KIND_RPAREN    = 5'd7,
    KIND_PERIOD    = 5'd8,
    KIND_SEMICOLON = 5'd9,
    KIND_ASSIGN    = 5'd10,
    KIND_IDENT     = 5'd11,
    KIND_DECLARE   = 5'd12,
    KIND_BEGIN     = 5'd13,
    KIND_END       = 5'd14,
    KIND_WRITELN   = 5'd15,
    KIND_COMMA     = 5'd16,
    KIND_EOI       = 5'd17
  } token_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE         = 2'd0,
    ERR_OVERFLOW     = 2'd1,
    ERR_UNKNOWN_CHAR = 2'd2,
    ERR_COLON        = 2'd3
  } err_code_t;

  // keyword spellings, first character in the lowest byte
  localparam logic [63:0] KW_BEGIN   = 64'h0000_004E_4947_4542;
  localparam logic [63:0] KW_DECLARE = 64'h0045_5241_4C43_4544;
  localparam logic [63:0] KW_END     = 64'h0000_0000_0044_4E45;
  localparam logic [63:0] KW_WRITELN = 64'h004E_4C45_5449_5257;

  typedef struct packed {
    logic        vld;
    logic        is_ident;   // needs keyword lookup in the back end
    token_kind_t kind;
    logic [14:0] value;
    logic [63:0] text;
    logic [3:0]  len;
    err_code_t   err;
  } token_t;

  // one accepted word can give a flushed token and a token of its own
  typedef struct packed {
    token_t t0;
    token_t t1;
  } step_rec_t;

  // largest accumulator value that still takes digit d without overflow
  function automatic logic [ACC_W-1:0] num_limit(input logic [3:0] d);
    logic [ACC_W-1:0] lim;
    unique case (d)
      4'd0:    lim = ACC_W'((MAX_NUMBER - 0) / 10);
      4'd1:    lim = ACC_W'((MAX_NUMBER - 1) / 10);
      4'd2:    lim = ACC_W'((MAX_NUMBER - 2) / 10);
      4'd3:    lim = ACC_W'((MAX_NUMBER - 3) / 10);
      4'd4:    lim = ACC_W'((MAX_NUMBER - 4) / 10);
      4'd5:    lim = ACC_W'((MAX_NUMBER - 5) / 10);
      4'd6:    lim = ACC_W'((MAX_NUMBER - 6) / 10);
      4'd7:    lim = ACC_W'((MAX_NUMBER - 7) / 10);
      4'd8:    lim = ACC_W'((MAX_NUMBER - 8) / 10);
      4'd9:    lim = ACC_W'((MAX_NUMBER - 9) / 10);
      default: lim = '0;
    endcase
    return lim;
  endfunction

endpackage

@@ hdl/stscan_front.sv @@
// Scanner front end: character classification and token state.
// Depends on stscan_pkg; emits one step record per word that yields tokens.
module stscan_front import stscan_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  logic [7:0] char_code,
  input  logic      is_end,
  output logic      rec_valid,
  output step_rec_t rec
);

  typedef enum logic [3:0] {
    MODE_IDLE   = 4'b0001,
    MODE_IDENT  = 4'b0010,
    MODE_NUMBER = 4'b0100,
    MODE_COLON  = 4'b1000
  } mode_t;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PERIOD = 8'h2E;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CASE_GAP  = 8'd32;

  mode_t            mode_r, mode_nxt;
  logic [63:0]      buf_r, buf_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic             ovf_r, ovf_nxt;

  logic        is_upper, is_lower, is_letter, is_digit, is_blank, do_idle;
  logic [7:0]  upper;
  logic [3:0]  digit;
  token_t      pending, tok;

  always_comb begin
    is_upper  = (char_code >= 8'h41) && (char_code <= 8'h5A);
    is_lower  = (char_code >= 8'h61) && (char_code <= 8'h7A);
    is_letter = is_upper || is_lower;
    is_digit  = (char_code >= CH_ZERO) && (char_code <= 8'h39);
    is_blank  = (char_code == CH_SPACE) || (char_code == CH_LF) || (char_code == CH_CR);
    upper     = is_lower ? (char_code - CASE_GAP) : char_code;
    digit     = 4'(char_code - CH_ZERO);
  end

  // token for whatever is in progress
  always_comb begin
    pending = '0;
    unique case (mode_r)
      MODE_IDENT: begin
        pending.vld      = 1'b1;
        pending.is_ident = 1'b1;
        pending.kind     = KIND_IDENT;
        pending.text     = buf_r;
        pending.len      = cnt_r;
      end
      MODE_NUMBER: begin
        pending.vld   = 1'b1;
        pending.kind  = KIND_NUMBER;
        pending.value = 15'(acc_r);
        pending.err   = ovf_r ? ERR_OVERFLOW : ERR_NONE;
      end
      MODE_COLON: begin
        pending.vld  = 1'b1;
        pending.kind = KIND_UNKNOWN;
        pending.err  = ERR_COLON;
      end
      default: pending = '0;
    endcase
  end

  always_comb begin
    mode_nxt = mode_r;
    buf_nxt  = buf_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    ovf_nxt  = ovf_r;
    rec      = '0;
    do_idle  = 1'b0;
    tok      = '0;

    if (is_end) begin
      rec.t0      = pending;
      rec.t1.vld  = 1'b1;
      rec.t1.kind = KIND_EOI;
      mode_nxt    = MODE_IDLE;
    end else begin
      unique case (mode_r)
        MODE_IDENT: begin
          if (is_letter || is_digit) begin
            if (cnt_r < 4'(IDENT_CHARS)) begin
              for (int i = 0; i < 8; i++) begin
                if (cnt_r == 4'(i)) buf_nxt[8*i +: 8] = upper;
              end
              cnt_nxt = cnt_r + 4'd1;
            end
          end else begin
            rec.t0  = pending;
            do_idle = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (is_digit) begin
            if (acc_r <= num_limit(digit))
              acc_nxt = ACC_W'(acc_r * ACC_W'(10) + ACC_W'(digit));
            else
              ovf_nxt = 1'b1;
          end else begin
            rec.t0  = pending;
            do_idle = 1'b1;
          end
        end
        MODE_COLON: begin
          rec.t0.vld = 1'b1;
          if (char_code == CH_EQUALS) begin
            rec.t0.kind = KIND_ASSIGN;
          end else begin
            rec.t0.kind = KIND_UNKNOWN;
            rec.t0.err  = ERR_COLON;
          end
          mode_nxt = MODE_IDLE;
        end
        default: do_idle = 1'b1;
      endcase
    end

    // the terminating character is scanned again from idle
    if (do_idle) begin
      mode_nxt = MODE_IDLE;
      if (is_blank) begin
        tok = '0;
      end else if (is_letter) begin
        mode_nxt = MODE_IDENT;
        buf_nxt  = {56'd0, upper};
        cnt_nxt  = 4'd1;
      end else if (is_digit) begin
        mode_nxt = MODE_NUMBER;
        acc_nxt  = ACC_W'(digit);
        ovf_nxt  = 1'b0;
      end else if (char_code == CH_COLON) begin
        mode_nxt = MODE_COLON;
      end else begin
        tok.vld = 1'b1;
        unique case (char_code)
          CH_PLUS:   tok.kind = KIND_PLUS;
          CH_MINUS:  tok.kind = KIND_MINUS;
          CH_STAR:   tok.kind = KIND_TIMES;
          CH_SLASH:  tok.kind = KIND_SLASH;
          CH_LPAREN: tok.kind = KIND_LPAREN;
          CH_RPAREN: tok.kind = KIND_RPAREN;
          CH_PERIOD: tok.kind = KIND_PERIOD;
          CH_SEMI:   tok.kind = KIND_SEMICOLON;
          CH_COMMA:  tok.kind = KIND_COMMA;
          default: begin
            tok.kind = KIND_UNKNOWN;
            tok.err  = ERR_UNKNOWN_CHAR;
          end
        endcase
      end
      rec.t1 = tok;
    end

    rec_valid = rec.t0.vld || rec.t1.vld;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      buf_r  <= '0;
      cnt_r  <= '0;
      acc_r  <= '0;
      ovf_r  <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      buf_r  <= buf_nxt;
      cnt_r  <= cnt_nxt;
      acc_r  <= acc_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

endmodule

@@ hdl/stscan_queue.sv @@
// Short queue of step records between the front end and the back end.
// Depends on stscan_pkg for the record type and depth.
module stscan_queue import stscan_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_en,
  input  step_rec_t wr_data,
  input  logic      rd_en,
  output step_rec_t rd_data,
  output logic      full,
  output logic      empty
);

  step_rec_t         mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_wr, do_rd;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) cnt_nxt = cnt_r + QCNT_W'(1);
    else if (do_rd && !do_wr) cnt_nxt = cnt_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (do_rd) rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ hdl/stscan_back.sv @@
// Token back end: keyword lookup and the output register.
// Depends on stscan_pkg; drains step records one token per cycle while the output register is empty or popped.
module stscan_back import stscan_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  step_rec_t   q_rec,
  input  logic        q_empty,
  output logic        q_pop,
  input  logic        out_pop,
  output logic        out_empty,
  output logic [4:0]  out_token_kind,
  output logic [14:0] out_number_value,
  output logic [63:0] out_ident_text,
  output logic [3:0]  out_ident_length,
  output logic [1:0]  out_error_code,
  output logic        out_last_in_run
);

  token_t tok_r, cur, looked;
  logic   last_r, vld_r, phase_r;
  logic   load, sel_t1, last;

  always_comb begin
    load   = !vld_r || out_pop;
    sel_t1 = phase_r || !q_rec.t0.vld;
    cur    = sel_t1 ? q_rec.t1 : q_rec.t0;
    last   = sel_t1 || !q_rec.t1.vld;
    q_pop  = load && !q_empty && last;

    looked = cur;
    if (cur.is_ident) begin
      priority if (cur.len == 4'd5 && cur.text == KW_BEGIN) begin
        looked.kind = KIND_BEGIN;
      end else if (cur.len == 4'd7 && cur.text == KW_DECLARE) begin
        looked.kind = KIND_DECLARE;
      end else if (cur.len == 4'd3 && cur.text == KW_END) begin
        looked.kind = KIND_END;
      end else if (cur.len == 4'd7 && cur.text == KW_WRITELN) begin
        looked.kind = KIND_WRITELN;
      end else begin
        looked.kind = KIND_IDENT;
      end
      // keywords carry no text
      if (looked.kind != KIND_IDENT) begin
        looked.text = '0;
        looked.len  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      tok_r  <= looked;
      last_r <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= 1'b0;
      phase_r <= 1'b0;
    end else if (load) begin
      vld_r <= !q_empty;
      if (!q_empty) phase_r <= !last;
    end
  end

  assign out_empty        = !vld_r;
  assign out_token_kind   = tok_r.kind;
  assign out_number_value = tok_r.value;
  assign out_ident_text   = tok_r.text;
  assign out_ident_length = tok_r.len;
  assign out_error_code   = tok_r.err;
  assign out_last_in_run  = last_r;

endmodule

@@ hdl/source_token_scanner_top.sv @@
// Source token scanner top level: front end, step queue, back end.
// Depends on stscan_pkg, stscan_front, stscan_queue and stscan_back.
//
//  channel | handshake           | payload
//  --------+---------------------+--------------------------------------------
//  in      | in_push / in_full   | in_char_code, in_is_end
//  out     | out_pop / out_empty | out_token_kind, out_number_value,
//          |                     | out_ident_text, out_ident_length,
//          |                     | out_error_code, out_last_in_run
//
// One character per cycle is taken while in_full is low; a token passes from the
// queue into the back end's output register, and the back end moves one token per
// cycle while that register is empty or popped, so a character that ends a token
// and makes one of its own yields two output tokens. The four-entry step queue sets
// how long the input runs ahead of a stalled output before in_full rises. Reset is
// synchronous and returns the scanner to idle with the step queue empty.
module source_token_scanner_top import stscan_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_char_code,
  input  logic        in_is_end,
  input  logic        out_pop,
  output logic        out_empty,
  output logic [4:0]  out_token_kind,
  output logic [14:0] out_number_value,
  output logic [63:0] out_ident_text,
  output logic [3:0]  out_ident_length,
  output logic [1:0]  out_error_code,
  output logic        out_last_in_run
);

  logic      accept, rec_valid, q_full, q_empty, q_pop;
  step_rec_t rec, q_rec;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  stscan_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .char_code (in_char_code),
    .is_end    (in_is_end),
    .rec_valid (rec_valid),
    .rec       (rec)
  );

  stscan_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept && rec_valid),
    .wr_data (rec),
    .rd_en   (q_pop),
    .rd_data (q_rec),
    .full    (q_full),
    .empty   (q_empty)
  );

  stscan_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_rec            (q_rec),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_token_kind   (out_token_kind),
    .out_number_value (out_number_value),
    .out_ident_text   (out_ident_text),
    .out_ident_length (out_ident_length),
    .out_error_code   (out_error_code),
    .out_last_in_run  (out_last_in_run)
  );

endmodule

@@ tb/sv/tb_source_token_scanner_top.sv @@
// Self-checking testbench for source_token_scanner_top: a scoreboard class
// predicts the tokens from each accepted character word and checks the output.
// Depends on stscan_pkg and the scanner RTL.
module tb_source_token_scanner_top;
  timeunit 1ns;
  timeprecision 1ps;
  import stscan_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 200;
  localparam int DRAIN_CYCLES   = 20;

  typedef enum logic [1:0] {
    SCAN_IDLE   = 2'd0,
    SCAN_IDENT  = 2'd1,
    SCAN_NUMBER = 2'd2,
    SCAN_COLON  = 2'd3
  } scan_mode_t;

  typedef struct {
    token_kind_t kind;
    logic [14:0] value;
    logic [63:0] text;
    logic [3:0]  len;
    err_code_t   err;
    logic        last;
  } scan_token_t;

  class token_scoreboard;
    scan_mode_t  mode;
    logic [63:0] name_chars;
    int          name_len;
    int          num_acc;
    bit          num_ovf;
    scan_token_t step_tokens[$];
    scan_token_t expected_tokens[$];
    int          errors;

    function new();
      mode       = SCAN_IDLE;
      name_chars = '0;
      name_len   = 0;
      num_acc    = 0;
      num_ovf    = 1'b0;
      errors     = 0;
    endfunction

    function bit is_letter(logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
    endfunction

    function void add(token_kind_t k, logic [14:0] v, logic [63:0] t, logic [3:0] l,
                      err_code_t e);
      scan_token_t tk;
      tk.kind  = k;
      tk.value = v;
      tk.text  = t;
      tk.len   = l;
      tk.err   = e;
      tk.last  = 1'b0;
      step_tokens.push_back(tk);
    endfunction

    function void append_letter(logic [7:0] c);
      if (c >= 8'h61 && c <= 8'h7A) c = c - 8'd32;
      if (name_len < IDENT_CHARS) begin
        name_chars[8*name_len +: 8] = c;
        name_len++;
      end
    endfunction

    function void append_digit(logic [7:0] c);
      int d;
      d = c - 8'h30;
      if (num_acc <= (MAX_NUMBER - d) / 10) num_acc = num_acc * 10 + d;
      else num_ovf = 1'b1;
    endfunction

    // keywords come out bare, without text or length
    function void flush_word();
      if (name_len == 5 && name_chars == KW_BEGIN) add(KIND_BEGIN, '0, '0, '0, ERR_NONE);
      else if (name_len == 7 && name_chars == KW_DECLARE)
        add(KIND_DECLARE, '0, '0, '0, ERR_NONE);
      else if (name_len == 3 && name_chars == KW_END) add(KIND_END, '0, '0, '0, ERR_NONE);
      else if (name_len == 7 && name_chars == KW_WRITELN)
        add(KIND_WRITELN, '0, '0, '0, ERR_NONE);
      else add(KIND_IDENT, '0, name_chars, 4'(name_len), ERR_NONE);
    endfunction

    function void flush_pending();
      case (mode)
        SCAN_IDENT:  flush_word();
        SCAN_NUMBER: begin
          if (num_ovf) add(KIND_NUMBER, num_acc[14:0], '0, '0, ERR_OVERFLOW);
          else add(KIND_NUMBER, num_acc[14:0], '0, '0, ERR_NONE);
        end
        SCAN_COLON:  add(KIND_UNKNOWN, '0, '0, '0, ERR_COLON);
        default: ;
      endcase
      mode = SCAN_IDLE;
    endfunction

    function void scan_from_idle(logic [7:0] c);
      if (c == 8'd32 || c == 8'd10 || c == 8'd13) return;
      if (is_letter(c)) begin
        mode       = SCAN_IDENT;
        name_chars = '0;
        name_len   = 0;
        append_letter(c);
      end else if (is_digit(c)) begin
        mode    = SCAN_NUMBER;
        num_acc = 0;
        num_ovf = 1'b0;
        append_digit(c);
      end else begin
        case (c)
          "+":     add(KIND_PLUS, '0, '0, '0, ERR_NONE);
          "-":     add(KIND_MINUS, '0, '0, '0, ERR_NONE);
          "*":     add(KIND_TIMES, '0, '0, '0, ERR_NONE);
          "/":     add(KIND_SLASH, '0, '0, '0, ERR_NONE);
          "(":     add(KIND_LPAREN, '0, '0, '0, ERR_NONE);
          ")":     add(KIND_RPAREN, '0, '0, '0, ERR_NONE);
          ".":     add(KIND_PERIOD, '0, '0, '0, ERR_NONE);
          ";":     add(KIND_SEMICOLON, '0, '0, '0, ERR_NONE);
          ",":     add(KIND_COMMA, '0, '0, '0, ERR_NONE);
          ":":     mode = SCAN_COLON;
          default: add(KIND_UNKNOWN, '0, '0, '0, ERR_UNKNOWN_CHAR);
        endcase
      end
    endfunction

    function void note_input(logic [7:0] c, logic is_end);
      step_tokens.delete();
      if (is_end) begin
        flush_pending();
        add(KIND_EOI, '0, '0, '0, ERR_NONE);
      end else begin
        case (mode)
          SCAN_IDENT: begin
            if (is_letter(c) || is_digit(c)) append_letter(c);
            else begin
              flush_pending();
              scan_from_idle(c);
            end
          end
          SCAN_NUMBER: begin
            if (is_digit(c)) append_digit(c);
            else begin
              flush_pending();
              scan_from_idle(c);
            end
          end
          SCAN_COLON: begin
            // the character after a colon is swallowed either way
            if (c == "=") add(KIND_ASSIGN, '0, '0, '0, ERR_NONE);
            else add(KIND_UNKNOWN, '0, '0, '0, ERR_COLON);
            mode = SCAN_IDLE;
          end
          default: scan_from_idle(c);
        endcase
      end
      if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
      foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
    endfunction

    function void report(string field, logic [63:0] exp_v, logic [63:0] act_v);
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, exp_v, act_v);
      errors++;
    endfunction

    function void check_token(logic [4:0] kind, logic [14:0] value, logic [63:0] text,
                              logic [3:0] len, logic [1:0] err, logic last);
      scan_token_t exp;
      if (expected_tokens.size() == 0) begin
        $display("%0t: unexpected token: expected none, actual kind %0d", $time, kind);
        errors++;
        return;
      end
      exp = expected_tokens.pop_front();
      if (exp.kind !== kind) report("token_kind", exp.kind, kind);
      if (exp.value !== value) report("number_value", exp.value, value);
      if (exp.text !== text) report("ident_text", exp.text, text);
      if (exp.len !== len) report("ident_length", exp.len, len);
      if (exp.err !== err) report("error_code", exp.err, err);
      if (exp.last !== last) report("last_in_run", exp.last, last);
    endfunction
  endclass

  logic        clk;
  logic        rst_n            = 1'b0;
  logic        in_push          = 1'b0;
  logic        in_full;
  logic [7:0]  in_char_code     = 8'd0;
  logic        in_is_end        = 1'b0;
  logic        out_pop          = 1'b0;
  logic        out_empty;
  logic [4:0]  out_token_kind;
  logic [14:0] out_number_value;
  logic [63:0] out_ident_text;
  logic [3:0]  out_ident_length;
  logic [1:0]  out_error_code;
  logic        out_last_in_run;

  token_scoreboard sb = new();
  int    send_idle_pct = 0;
  int    pop_stall_pct = 0;
  int    hold_cycles   = 0;
  int    chars_sent    = 0;
  string keywords[4]   = '{"BEGIN", "DECLARE", "END", "WRITELN"};
  string punctuation   = "+-*/().;,";

  source_token_scanner_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_char_code     (in_char_code),
    .in_is_end        (in_is_end),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_token_kind   (out_token_kind),
    .out_number_value (out_number_value),
    .out_ident_text   (out_ident_text),
    .out_ident_length (out_ident_length),
    .out_error_code   (out_error_code),
    .out_last_in_run  (out_last_in_run)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_char(logic [7:0] c, logic is_end);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push      <= 1'b1;
    in_char_code <= c;
    in_is_end    <= is_end;
    do @(posedge clk); while (in_full);
    sb.note_input(c, is_end);
    chars_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] base;
    base = $urandom_range(0, 1) ? 8'h41 : 8'h61;
    return base + 8'($urandom_range(0, 25));
  endfunction

  // one lexeme, mostly well formed, then maybe a blank
  task automatic send_lexeme();
    int         pick;
    int         n;
    string      w;
    logic [7:0] c;
    logic [7:0] blanks [3];
    blanks = '{8'd32, 8'd10, 8'd13};
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      w = keywords[$urandom_range(0, 3)];
      for (int j = 0; j < w.len(); j++) begin
        c = w[j];
        if ($urandom_range(0, 1)) c = c | 8'h20;
        send_char(c, 1'b0);
      end
    end else if (pick < 35) begin
      n = $urandom_range(0, 3) == 0 ? $urandom_range(9, 12) : $urandom_range(1, 8);
      send_char(rand_letter(), 1'b0);
      for (int j = 1; j < n; j++) begin
        if ($urandom_range(0, 9) < 7) send_char(rand_letter(), 1'b0);
        else send_char(8'h30 + 8'($urandom_range(0, 9)), 1'b0);
      end
    end else if (pick < 55) begin
      n = $urandom_range(0, 4) == 0 ? $urandom_range(5, 7) : $urandom_range(1, 4);
      for (int j = 0; j < n; j++) send_char(8'h30 + 8'($urandom_range(0, 9)), 1'b0);
    end else if (pick < 75) begin
      send_char(punctuation[$urandom_range(0, 8)], 1'b0);
    end else if (pick < 82) begin
      send_text(":=");
    end else if (pick < 86) begin
      send_char(":", 1'b0);
      send_char(8'($urandom_range(0, 255)), 1'b0);
    end else if (pick < 92) begin
      send_char(8'($urandom_range(0, 255)), 1'b0);
    end else if (pick < 95) begin
      send_char(8'($urandom_range(0, 255)), 1'b1);
    end
    if ($urandom_range(0, 1)) send_char(blanks[$urandom_range(0, 2)], 1'b0);
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, int n_chars);
    int target;
    send_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    target        = chars_sent + n_chars;
    while (chars_sent < target) send_lexeme();
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_cycles > 0) begin
        out_pop <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else begin
        out_pop <= ($urandom_range(0, 99) >= pop_stall_pct);
        @(posedge clk);
        if (out_pop && !out_empty)
          sb.check_token(out_token_kind, out_number_value, out_ident_text,
                         out_ident_length, out_error_code, out_last_in_run);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (rst_n && !((in_push && !in_full) || (out_pop && !out_empty))) quiet++;
      else quiet = 0;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // keyword then operator, digits inside a name, overflow, assign and a
    // broken colon, byte extremes, colon pending at end, repeated end marks
    send_text("end*Zz9/32768(:=:)-;");
    send_char(8'd0, 1'b0);
    send_char(8'd255, 1'b0);
    send_text(".,:");
    send_char(8'd0, 1'b1);
    send_char(8'd255, 1'b1);

    // output held off while input keeps coming until in_full stalls it
    hold_cycles = HOLD_CYCLES;
    run_phase(0, 0, 60);
    run_phase(0, 0, 115);
    run_phase(70, 0, 115);
    run_phase(0, 70, 115);
    run_phase(11, 11, 115);
    in_push <= 1'b0;

    while (sb.expected_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_tokens.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
